// File: rtl/core/lslf_pkg.sv
// Shared types and constants for the least-squares line fit.
// No dependencies; the divider, back end, top level and testbench use it by scoped name.
`timescale 1ns / 1ps

package lslf_pkg;

    // Shared divider: Q16 dividend and 64-bit divisor
    localparam int DIVIDEND_W = 80;
    localparam int DIVISOR_W  = 64;
    localparam int DIV_CNT_W  = 7;

    // Accumulators of the second pass wrap at 64 bits
    localparam int ACC_W = 64;

    localparam int STATUS_W = 2;
    localparam int POINTS_W = 11;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_VAR  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 2'd3;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PASS,
        BK_DRAIN,
        BK_SLOPE,
        BK_IMUL,
        BK_ISTART,
        BK_ICPT,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

// File: rtl/core/lslf_front.sv
// Front end: accepts sample beats, keeps count and sums, holds the sample store.
// Depends on no other file; nothing from lslf_pkg is used.
`timescale 1ns / 1ps

module lslf_front #(
    parameter int MAX_POINTS = 1024,
    parameter int CNT_W      = $clog2(MAX_POINTS + 1),
    parameter int AW         = $clog2(MAX_POINTS),
    parameter int SUM_W      = 17 + $clog2(MAX_POINTS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [15:0]      x_sample,
    input  logic signed [15:0]      y_sample,
    input  logic                    last_sample,
    input  logic [AW-1:0]           rd_addr,
    output logic signed [15:0]      rd_x,
    output logic signed [15:0]      rd_y,
    output logic                    job_push,
    input  logic                    job_room,
    output logic [CNT_W-1:0]        job_n,
    output logic signed [SUM_W-1:0] job_sum_x,
    output logic signed [SUM_W-1:0] job_sum_y,
    output logic                    job_ovf,
    input  logic                    pass_done
);

    logic signed [15:0] x_mem [MAX_POINTS];
    logic signed [15:0] y_mem [MAX_POINTS];

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic                    ovf_reg, ovf_next;
    logic                    hold_reg;
    logic                    accept;
    logic                    room;

    assign in_ready = !hold_reg && job_room;
    assign accept   = in_valid && in_ready;
    assign room     = count_reg < CNT_W'(MAX_POINTS);

    always_comb
    begin
        count_next = count_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        ovf_next   = ovf_reg;
        if (room)
        begin
            count_next = count_reg + CNT_W'(1);
            sum_x_next = sum_x_reg + SUM_W'(x_sample);
            sum_y_next = sum_y_reg + SUM_W'(y_sample);
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign job_push  = accept && last_sample;
    assign job_n     = count_next;
    assign job_sum_x = sum_x_next;
    assign job_sum_y = sum_y_next;
    assign job_ovf   = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            ovf_reg   <= 1'b0;
            hold_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last_sample)
                begin
                    // clear for the next set, hold until the store is read out
                    count_reg <= '0;
                    sum_x_reg <= '0;
                    sum_y_reg <= '0;
                    ovf_reg   <= 1'b0;
                    hold_reg  <= 1'b1;
                end
                else
                begin
                    count_reg <= count_next;
                    sum_x_reg <= sum_x_next;
                    sum_y_reg <= sum_y_next;
                    ovf_reg   <= ovf_next;
                end
            end
            else if (pass_done)
            begin
                hold_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            x_mem[count_reg[AW-1:0]] <= x_sample;
            y_mem[count_reg[AW-1:0]] <= y_sample;
        end
        rd_x <= x_mem[rd_addr];
        rd_y <= y_mem[rd_addr];
    end

endmodule

// File: rtl/core/lslf_queue.sv
// Two-entry job queue between front and back end.
// Depends on nothing but its WIDTH parameter.
`timescale 1ns / 1ps

module lslf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    output logic             wr_room,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       fill_reg;

    assign wr_room  = fill_reg != 2'd2;
    assign rd_valid = fill_reg != 2'd0;
    assign rd_data  = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (wr_en && wr_room)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (rd_en && rd_valid)
            begin
                rptr_reg <= !rptr_reg;
            end
            fill_reg <= fill_reg + 2'((wr_en && wr_room) ? 1 : 0)
                                 - 2'((rd_en && rd_valid) ? 1 : 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_room)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/core/lslf_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on lslf_pkg for widths and the control struct.
`timescale 1ns / 1ps

module lslf_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lslf_pkg::div_ctrl_t              ctrl_in,
    output lslf_pkg::div_ctrl_t              ctrl_out,
    input  logic [lslf_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [lslf_pkg::DIVISOR_W-1:0]   divisor,
    output logic [lslf_pkg::DIVIDEND_W-1:0]  quotient
);

    logic [lslf_pkg::DIVISOR_W:0]     rem_reg;
    logic [lslf_pkg::DIVIDEND_W-1:0]  quo_reg;
    logic [lslf_pkg::DIVISOR_W-1:0]   dsr_reg;
    logic [lslf_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [lslf_pkg::DIVISOR_W:0]     trial;
    logic                             ge;

    assign trial    = {rem_reg[lslf_pkg::DIVISOR_W-1:0], quo_reg[lslf_pkg::DIVIDEND_W-1]};
    assign ge       = trial >= {1'b0, dsr_reg};
    assign quotient = quo_reg;

    always_comb
    begin
        ctrl_out.start = busy_reg;
        ctrl_out.done  = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl_in.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + lslf_pkg::DIV_CNT_W'(1);
                if (cnt_reg == lslf_pkg::DIV_CNT_W'(lslf_pkg::DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial - {1'b0, dsr_reg} : trial;
            quo_reg <= {quo_reg[lslf_pkg::DIVIDEND_W-2:0], ge};
        end
    end

endmodule

// File: rtl/core/lslf_back.sv
// Back end: second pass over the store, slope and intercept division, result register.
// Depends on lslf_pkg and drives lslf_div.
`timescale 1ns / 1ps

module lslf_back #(
    parameter int MAX_POINTS = 1024,
    parameter int CNT_W      = $clog2(MAX_POINTS + 1),
    parameter int AW         = $clog2(MAX_POINTS),
    parameter int SUM_W      = 17 + $clog2(MAX_POINTS)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 job_valid,
    output logic                                 job_pop,
    input  logic [CNT_W-1:0]                     job_n,
    input  logic signed [SUM_W-1:0]              job_sum_x,
    input  logic signed [SUM_W-1:0]              job_sum_y,
    input  logic                                 job_ovf,
    output logic [AW-1:0]                        rd_addr,
    input  logic signed [15:0]                   rd_x,
    input  logic signed [15:0]                   rd_y,
    output logic                                 pass_done,
    output lslf_pkg::div_ctrl_t                  div_req,
    input  lslf_pkg::div_ctrl_t                  div_rsp,
    output logic [lslf_pkg::DIVIDEND_W-1:0]      div_dividend,
    output logic [lslf_pkg::DIVISOR_W-1:0]       div_divisor,
    input  logic [lslf_pkg::DIVIDEND_W-1:0]      div_quotient,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [31:0]                   slope,
    output logic signed [31:0]                   intercept,
    output logic [lslf_pkg::STATUS_W-1:0]        fit_status,
    output logic [lslf_pkg::POINTS_W-1:0]        points_used
);

    localparam int T_W  = CNT_W + 18;
    localparam int P_W  = T_W + 16;
    localparam int IN_W = SUM_W + 34;
    localparam int ACC_W = lslf_pkg::ACC_W;
    localparam int DVD_W = lslf_pkg::DIVIDEND_W;

    lslf_pkg::back_state_t state_reg, state_next;

    logic [CNT_W-1:0]        n_reg;
    logic signed [SUM_W-1:0] sx_reg;
    logic signed [SUM_W-1:0] sy_reg;
    logic                    ovf_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [T_W-1:0]   t_reg, u_reg;
    logic signed [15:0]      x1_reg;
    logic signed [P_W-1:0]   pn_reg, pd_reg;
    logic [ACC_W-1:0]        num_reg, den_reg;
    logic                    zero_var;
    logic                    zero_var_reg;
    logic signed [31:0]      slope_reg;
    logic                    sat_reg;
    logic signed [IN_W-1:0]  inum_reg;
    logic [ACC_W-1:0]        num_mag;
    logic [IN_W-1:0]         inum_mag;
    logic                    pipe_busy;
    logic                    issue;

    logic                    out_valid_reg;
    logic signed [31:0]      slope_out_reg, icpt_out_reg;
    logic [lslf_pkg::STATUS_W-1:0] status_out_reg;
    logic [lslf_pkg::POINTS_W-1:0] points_out_reg;

    // slope and intercept after saturation
    logic signed [31:0]      slope_q;
    logic                    slope_sat;
    logic signed [31:0]      icpt_q;
    logic                    icpt_sat;
    logic [31:0]             q32;

    assign pipe_busy = v1_reg || v2_reg || v3_reg;
    assign zero_var  = (den_reg == '0) || den_reg[ACC_W-1];
    assign num_mag   = num_reg[ACC_W-1] ? ACC_W'(0) - num_reg : num_reg;
    assign inum_mag  = inum_reg[IN_W-1] ? IN_W'(0) - IN_W'(inum_reg) : IN_W'(inum_reg);
    assign rd_addr   = idx_reg[AW-1:0];
    assign q32       = div_quotient[31:0];

    always_comb
    begin
        slope_sat = 1'b0;
        slope_q   = $signed(q32);
        if (|div_quotient[DVD_W-1:32])
        begin
            slope_sat = 1'b1;
            slope_q   = num_reg[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else if (num_reg[ACC_W-1])
        begin
            if (q32 > 32'h8000_0000)
            begin
                slope_sat = 1'b1;
                slope_q   = 32'sh8000_0000;
            end
            else
            begin
                slope_q = $signed(32'(0) - q32);
            end
        end
        else if (q32[31])
        begin
            slope_sat = 1'b1;
            slope_q   = 32'sh7fff_ffff;
        end
    end

    always_comb
    begin
        icpt_sat = 1'b0;
        icpt_q   = $signed(q32);
        if (inum_reg[IN_W-1])
        begin
            if ((|div_quotient[DVD_W-1:32]) || q32 > 32'h8000_0000)
            begin
                icpt_sat = 1'b1;
                icpt_q   = 32'sh8000_0000;
            end
            else
            begin
                icpt_q = $signed(32'(0) - q32);
            end
        end
        else if (|div_quotient[DVD_W-1:31])
        begin
            icpt_sat = 1'b1;
            icpt_q   = 32'sh7fff_ffff;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        job_pop       = 1'b0;
        issue         = 1'b0;
        pass_done     = 1'b0;
        div_req.start = 1'b0;
        div_req.done  = 1'b0;
        if (state_reg == lslf_pkg::BK_DRAIN)
        begin
            div_dividend = {num_mag, 16'b0};
            div_divisor  = den_reg;
        end
        else
        begin
            div_dividend = DVD_W'(inum_mag >> 8);
            div_divisor  = lslf_pkg::DIVISOR_W'(n_reg);
        end
        unique case (state_reg)
            lslf_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    state_next = lslf_pkg::BK_PASS;
                end
            end
            lslf_pkg::BK_PASS:
            begin
                issue = 1'b1;
                if (idx_reg == n_reg - CNT_W'(1))
                begin
                    state_next = lslf_pkg::BK_DRAIN;
                end
            end
            lslf_pkg::BK_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    pass_done = 1'b1;
                    if (zero_var)
                    begin
                        state_next = lslf_pkg::BK_IMUL;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = lslf_pkg::BK_SLOPE;
                    end
                end
            end
            lslf_pkg::BK_SLOPE:
            begin
                if (div_rsp.done)
                begin
                    state_next = lslf_pkg::BK_IMUL;
                end
            end
            lslf_pkg::BK_IMUL:
            begin
                state_next = lslf_pkg::BK_ISTART;
            end
            lslf_pkg::BK_ISTART:
            begin
                div_req.start = 1'b1;
                state_next    = lslf_pkg::BK_ICPT;
            end
            lslf_pkg::BK_ICPT:
            begin
                if (div_rsp.done)
                begin
                    state_next = lslf_pkg::BK_OUT;
                end
            end
            lslf_pkg::BK_OUT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = lslf_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lslf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lslf_pkg::BK_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (state_reg == lslf_pkg::BK_OUT && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            n_reg   <= job_n;
            sx_reg  <= job_sum_x;
            sy_reg  <= job_sum_y;
            ovf_reg <= job_ovf;
            idx_reg <= '0;
            num_reg <= '0;
            den_reg <= '0;
        end
        if (issue)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        // stage one: n*y - sum_y and n*x - sum_x
        t_reg  <= T_W'($signed({1'b0, n_reg}) * rd_y) - T_W'(sy_reg);
        u_reg  <= T_W'($signed({1'b0, n_reg}) * rd_x) - T_W'(sx_reg);
        x1_reg <= rd_x;
        // stage two: weight by x
        pn_reg <= P_W'(x1_reg * t_reg);
        pd_reg <= P_W'(x1_reg * u_reg);
        // stage three: wrap-around accumulate
        if (v3_reg)
        begin
            num_reg <= num_reg + ACC_W'(pn_reg);
            den_reg <= den_reg + ACC_W'(pd_reg);
        end
        if (state_reg == lslf_pkg::BK_DRAIN && !pipe_busy)
        begin
            zero_var_reg <= zero_var;
            slope_reg    <= '0;
            sat_reg      <= 1'b0;
        end
        if (state_reg == lslf_pkg::BK_SLOPE && div_rsp.done)
        begin
            slope_reg <= slope_q;
            sat_reg   <= slope_sat;
        end
        if (state_reg == lslf_pkg::BK_IMUL)
        begin
            inum_reg <= (IN_W'(sy_reg) <<< 16) - IN_W'(slope_reg * sx_reg);
        end
        // load the result register only once the previous beat has left;
        // the divider holds the intercept quotient until the next job starts
        if (state_reg == lslf_pkg::BK_OUT && !out_valid_reg)
        begin
            icpt_out_reg  <= icpt_q;
            slope_out_reg <= slope_reg;
            points_out_reg <= lslf_pkg::POINTS_W'(n_reg);
            if (zero_var_reg)
            begin
                status_out_reg <= lslf_pkg::ST_ZERO_VAR;
            end
            else if (ovf_reg)
            begin
                status_out_reg <= lslf_pkg::ST_DROPPED;
            end
            else if (sat_reg || icpt_sat)
            begin
                status_out_reg <= lslf_pkg::ST_SATURATED;
            end
            else
            begin
                status_out_reg <= lslf_pkg::ST_OK;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign slope       = slope_out_reg;
    assign intercept   = icpt_out_reg;
    assign fit_status  = status_out_reg;
    assign points_used = points_out_reg;

endmodule

// File: rtl/core/least_squares_line_fit.sv
// Top level of the least-squares line fit: front end, job queue, back end, divider.
// Depends on lslf_pkg, lslf_front, lslf_queue, lslf_div and lslf_back.
`timescale 1ns / 1ps
//
//  Channel   Handshake             Beat carries
//  -------   -------------------   ---------------------------------------------
//  samples   in_valid / in_ready   x_sample, y_sample (Q8.8), last_sample
//  result    out_valid/out_ready   slope, intercept (Q16.16), fit_status, points_used
//
//  An ordinary sample beat writes the store and updates the running sums in the front end.
//  A last beat queues a fit job; the back end then reads the store once, one sample a
//  cycle, so the sample channel stalls until that pass ends. The intercept, and the
//  slope unless x has no spread, are computed in turn on the shared bit-serial divider;
//  new samples flow meanwhile. Reset clears counts, sums and the handshake state; the
//  store needs no clearing pass. The result register holds its beat until out_ready,
//  and the back end waits on it.

module least_squares_line_fit #(
    parameter int MAX_POINTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] x_sample,
    input  logic signed [15:0] y_sample,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] slope,
    output logic signed [31:0] intercept,
    output logic [1:0]         fit_status,
    output logic [10:0]        points_used
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int SUM_W = 17 + $clog2(MAX_POINTS);
    localparam int JOB_W = 1 + 2 * SUM_W + CNT_W;

    logic [AW-1:0]           rd_addr;
    logic signed [15:0]      rd_x, rd_y;
    logic                    job_push, job_room, job_valid, job_pop, job_ovf;
    logic [CNT_W-1:0]        job_n;
    logic signed [SUM_W-1:0] job_sum_x, job_sum_y;
    logic [JOB_W-1:0]        job_wr, job_rd;
    logic                    pass_done;

    lslf_pkg::div_ctrl_t                 div_req, div_rsp;
    logic [lslf_pkg::DIVIDEND_W-1:0]     div_dividend, div_quotient;
    logic [lslf_pkg::DIVISOR_W-1:0]      div_divisor;

    // front end: take sample beats, fill the store, keep running sums
    lslf_front #(
        .MAX_POINTS (MAX_POINTS),
        .CNT_W      (CNT_W),
        .AW         (AW),
        .SUM_W      (SUM_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_sample    (x_sample),
        .y_sample    (y_sample),
        .last_sample (last_sample),
        .rd_addr     (rd_addr),
        .rd_x        (rd_x),
        .rd_y        (rd_y),
        .job_push    (job_push),
        .job_room    (job_room),
        .job_n       (job_n),
        .job_sum_x   (job_sum_x),
        .job_sum_y   (job_sum_y),
        .job_ovf     (job_ovf),
        .pass_done   (pass_done)
    );

    assign job_wr = {job_ovf, job_sum_y, job_sum_x, job_n};

    // hold fit jobs so each side stalls on its own
    lslf_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_room  (job_room),
        .wr_data  (job_wr),
        .rd_valid (job_valid),
        .rd_en    (job_pop),
        .rd_data  (job_rd)
    );

    lslf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (div_req),
        .ctrl_out (div_rsp),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient)
    );

    // back end: second pass, divisions, result beat
    lslf_back #(
        .MAX_POINTS (MAX_POINTS),
        .CNT_W      (CNT_W),
        .AW         (AW),
        .SUM_W      (SUM_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_pop      (job_pop),
        .job_n        (job_rd[CNT_W-1:0]),
        .job_sum_x    (job_rd[CNT_W +: SUM_W]),
        .job_sum_y    (job_rd[CNT_W + SUM_W +: SUM_W]),
        .job_ovf      (job_rd[JOB_W-1]),
        .rd_addr      (rd_addr),
        .rd_x         (rd_x),
        .rd_y         (rd_y),
        .pass_done    (pass_done),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_quotient (div_quotient),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .slope        (slope),
        .intercept    (intercept),
        .fit_status   (fit_status),
        .points_used  (points_used)
    );

endmodule

// File: dv/tb_least_squares_line_fit.sv
// Self-checking testbench for least_squares_line_fit: random and directed sample sets.
// Depends on lslf_pkg and the block's RTL; fits are predicted in place and checked per beat.
`timescale 1ns / 1ps

module tb_least_squares_line_fit;

    localparam int  CAP       = 1024;
    localparam int  RAND_GOAL = 930;
    localparam int  NPHASES   = 4;
    localparam longint S32MAX = 64'sd2147483647;
    localparam longint S32MIN = -64'sd2147483648;

    // One sample beat as queued for the driver, tagged with its idling phase
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        int                 phase;
    } sample_t;

    typedef struct {
        logic signed [31:0] slope;
        logic signed [31:0] icpt;
        logic [1:0]         status;
        logic [10:0]        points;
    } fit_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;
    logic               last_sample;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [1:0]         fit_status;
    logic [10:0]        points_used;

    sample_t pending_samples[$];
    fit_t    expected_fits[$];

    // Predictor copy of the set being collected
    shortint set_x[CAP];
    shortint set_y[CAP];
    int      set_count;
    longint  set_sum_x;
    longint  set_sum_y;
    bit      set_dropped;

    int  errors;
    int  fits_seen;
    int  samples_taken;
    int  status_seen[4];
    int  cur_phase;
    bit  hold_off;
    bit  in_beat;
    bit  gen_done;

    least_squares_line_fit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_sample    (x_sample),
        .y_sample    (y_sample),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .slope       (slope),
        .intercept   (intercept),
        .fit_status  (fit_status),
        .points_used (points_used)
    );

    always #5 clk = ~clk;

    // Clamp to the signed 32-bit range and note any clipping
    function automatic longint clamp32(longint v, inout bit sat);
        if (v > S32MAX)
        begin
            sat = 1'b1;
            return S32MAX;
        end
        if (v < S32MIN)
        begin
            sat = 1'b1;
            return S32MIN;
        end
        return v;
    endfunction

    // Fit the stored set: exact integer sums that wrap at 64 bits, then the Q16 divisions
    function automatic fit_t fit_line();
        fit_t            r;
        longint          n;
        longint          num;
        longint          den;
        longint          slp;
        longint          ic;
        longint          xi;
        longint          yi;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned dv;
        bit              neg;
        bit              sat;
        n   = set_count;
        num = 0;
        den = 0;
        sat = 1'b0;
        for (int i = 0; i < set_count; i++)
        begin
            xi  = set_x[i];
            yi  = set_y[i];
            num += xi * (n * yi - set_sum_y);
            den += xi * (n * xi - set_sum_x);
        end
        if (den <= 0)
        begin
            // no spread in x: report the mean of y as a flat line
            slp      = 0;
            ic       = clamp32((set_sum_y * 256) / n, sat);
            r.status = lslf_pkg::ST_ZERO_VAR;
        end
        else
        begin
            neg = num < 0;
            mag = neg ? 64'd0 - longint'(num) : num;
            dv  = den;
            q   = mag / dv;
            rem = mag % dv;
            if (q >= 65536)
            begin
                sat = 1'b1;
                slp = neg ? S32MIN : S32MAX;
            end
            else
            begin
                for (int i = 0; i < 16; i++)
                begin
                    rem = rem << 1;
                    q   = q << 1;
                    if (rem >= dv)
                    begin
                        rem = rem - dv;
                        q   = q | 1;
                    end
                end
                if (neg)
                begin
                    if (q > 64'h8000_0000)
                    begin
                        sat = 1'b1;
                        slp = S32MIN;
                    end
                    else
                        slp = -longint'(q);
                end
                else if (q > 64'h7FFF_FFFF)
                begin
                    sat = 1'b1;
                    slp = S32MAX;
                end
                else
                    slp = q;
            end
            ic = clamp32((set_sum_y * 65536 - slp * set_sum_x) / (n * 256), sat);
            r.status = set_dropped ? lslf_pkg::ST_DROPPED :
                       (sat ? lslf_pkg::ST_SATURATED : lslf_pkg::ST_OK);
        end
        r.slope  = slp[31:0];
        r.icpt   = ic[31:0];
        r.points = set_count[10:0];
        return r;
    endfunction

    // Take one accepted beat into the predictor; a last beat closes the set
    task automatic take_sample(logic signed [15:0] x, logic signed [15:0] y, logic last);
        if (set_count < CAP)
        begin
            set_x[set_count] = x;
            set_y[set_count] = y;
            set_count++;
            set_sum_x += x;
            set_sum_y += y;
        end
        else
            set_dropped = 1'b1;
        if (last)
        begin
            expected_fits.insert(expected_fits.size(), fit_line());
            set_count   = 0;
            set_sum_x   = 0;
            set_sum_y   = 0;
            set_dropped = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on fit %0d: %s got %0d expected %0d", fits_seen, what, got, want);
    endtask

    task automatic queue_sample(int x, int y, bit last, int phase);
        sample_t s;
        s.x     = x[15:0];
        s.y     = y[15:0];
        s.last  = last;
        s.phase = phase;
        pending_samples.insert(pending_samples.size(), s);
    endtask

    // Sample both channels on the rising edge; predict on input beats, check on output beats
    always @(posedge clk)
    begin
        fit_t want;
        in_beat = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                in_beat = 1'b1;
                samples_taken++;
                take_sample(x_sample, y_sample, last_sample);
            end
            if (out_valid && out_ready)
            begin
                if (expected_fits.size() == 0)
                begin
                    report_mismatch("unexpected fit beat, slope", slope, 0);
                end
                else
                begin
                    want = expected_fits.pop_front();
                    if (slope !== want.slope)
                        report_mismatch("slope", slope, want.slope);
                    if (intercept !== want.icpt)
                        report_mismatch("intercept", intercept, want.icpt);
                    if (fit_status !== want.status)
                        report_mismatch("fit_status", fit_status, want.status);
                    if (points_used !== want.points)
                        report_mismatch("points_used", points_used, want.points);
                    status_seen[want.status]++;
                end
                fits_seen++;
            end
        end
    end

    // Drive on the falling edge: advance to the next sample once the current one is taken
    always @(negedge clk)
    begin
        sample_t s;
        int      idle_pct;
        int      stall_pct;
        if (rst_n)
        begin
            idle_pct  = (cur_phase == 1) ? 56 : (cur_phase == 3) ? 36 : 0;
            stall_pct = (cur_phase == 2) ? 56 : (cur_phase == 3) ? 36 : 0;
            if (!in_valid || in_beat)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    s           = pending_samples.pop_front();
                    cur_phase   = s.phase;
                    x_sample    <= s.x;
                    y_sample    <= s.y;
                    last_sample <= s.last;
                    in_valid    <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    // Hold the result channel off for a long stretch so the block backs up into its input
    initial
    begin
        hold_off = 1'b0;
        wait (cur_phase == 2);
        hold_off = 1'b1;
        repeat (4000) @(posedge clk);
        hold_off = 1'b0;
    end

    // Build the stimulus: directed sets first, then random sets spread over the idling phases
    initial
    begin
        int total;
        int len;
        int mode;
        int a;
        int b;
        int xv;
        int ph;
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        x_sample    = '0;
        y_sample    = '0;
        last_sample = 1'b0;
        errors      = 0;
        set_count   = 0;
        set_sum_x   = 0;
        set_sum_y   = 0;
        set_dropped = 1'b0;
        cur_phase   = 0;
        gen_done    = 1'b0;

        // single sample: no spread in x
        queue_sample(16'sh1234, -300, 1, 0);
        // two points at the extremes of both fields
        queue_sample(-32768, 32767, 0, 0);
        queue_sample(32767, -32768, 1, 0);
        queue_sample(-32768, -32768, 0, 0);
        queue_sample(32767, 32767, 1, 0);
        // vertical set: equal x, different y
        queue_sample(100, 5, 0, 0);
        queue_sample(100, -7000, 0, 0);
        queue_sample(100, 32767, 1, 0);
        // steep line: x one step apart, y far apart saturates the slope
        queue_sample(0, -32768, 0, 0);
        queue_sample(1, 32767, 1, 0);
        queue_sample(-1, 32767, 0, 0);
        queue_sample(0, -32768, 1, 0);
        // exact line y = 2x + 1.0
        for (int i = 0; i < 6; i++)
            queue_sample(i * 256, 2 * i * 256 + 256, i == 5, 0);

        total = 0;
        while (total < RAND_GOAL)
        begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 12);
            mode = $urandom_range(3);
            a    = $urandom_range(8) - 4;
            b    = $urandom_range(65535) - 32768;
            ph   = total * NPHASES / RAND_GOAL;
            xv   = $urandom_range(511) - 256;
            for (int i = 0; i < len; i++)
            begin
                case (mode)
                    0: queue_sample($urandom_range(65535), $urandom_range(65535),
                                    i == len - 1, ph);
                    1: queue_sample($urandom_range(16) - 8, $urandom_range(16) - 8,
                                    i == len - 1, ph);
                    2:
                    begin
                        xv = $urandom_range(4095) - 2048;
                        queue_sample(xv, a * xv + (b >>> 4) + $urandom_range(32),
                                     i == len - 1, ph);
                    end
                    default: queue_sample(xv, $urandom_range(65535), i == len - 1, ph);
                endcase
            end
            total += len;
        end
        gen_done = 1'b1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_samples.size() == 0 && !in_valid);
        wait (expected_fits.size() == 0);
        repeat (400) @(posedge clk);

        $display("%0d sample beats over %0d fits, four idling phases and one long output hold",
                 samples_taken, fits_seen);
        $display("status counts: ok %0d, zero variance %0d, saturated %0d, dropped %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && expected_fits.size() == 0)
            $display("[least_squares_line_fit] OK");
        else
            $display("[least_squares_line_fit] ERROR");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #20_000_000;
        $display("timeout with %0d fits outstanding", expected_fits.size());
        $display("[least_squares_line_fit] ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/core/lslf_pkg.sv
rtl/core/lslf_front.sv
rtl/core/lslf_queue.sv
rtl/core/lslf_div.sv
rtl/core/lslf_back.sv
rtl/core/least_squares_line_fit.sv
dv/tb_least_squares_line_fit.sv
